>>> src/priority_schedule_wait_times_defines.svh
// ============================================================================
// Priority scheduler assertion macros
// Shared concurrent assertion forms for the scheduler checker.
// ============================================================================
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psw_checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psw_checker: next-cycle implication failed");

`endif

>>> src/psw_pkg.sv
// ============================================================================
// Priority scheduler package
// Field widths, channel payload types and controller command types.
// ============================================================================
package psw_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 5;
  localparam int TIME_W  = 20;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last_job;
  } psw_in_t;

  typedef struct packed {
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] job_burst;
    logic [PRIO_W-1:0]  job_prio;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  avg_wait;
    logic [TIME_W-1:0]  avg_turnaround;
    logic               overflowed;
    logic               final_result;
  } psw_out_t;

  typedef struct packed {
    logic rd_en;
    logic load_wr;
    logic cur_load;
    logic cmp_step;
    logic row_wb;
    logic run_clr;
    logic acc_step;
    logic div_start;
    logic emit_load;
    logic last_res;
    logic ovf;
  } psw_cmd_t;

  typedef struct packed {
    logic div_done;
  } psw_sts_t;

endpackage

>>> src/psw_in_if.sv
// ============================================================================
// Priority scheduler job channel
// Valid/ready channel that carries one job per transfer.
// ============================================================================
interface psw_in_if;

  logic              valid;
  logic              ready;
  psw_pkg::psw_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> src/psw_out_if.sv
// ============================================================================
// Priority scheduler result channel
// Valid/ready channel that carries one scheduled job per transfer.
// ============================================================================
interface psw_out_if;

  logic              valid;
  logic              ready;
  psw_pkg::psw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> src/psw_div.sv
// ============================================================================
// Priority scheduler divider
// Restoring divider that retires one quotient bit per cycle.
// ============================================================================
module psw_div #(
  parameter int NW = 24,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   num_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;

  logic [DW:0]     sh;
  logic [DW:0]     diff;
  logic            ge;
  logic [DW-1:0]   rem_nxt;

  always_comb begin
    sh      = {rem_r, num_r[NW-1]};
    diff    = sh - {1'b0, den_r};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNTW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quot = num_r;
  assign done = done_r;

endmodule

>>> src/psw_ctrl.sv
// ============================================================================
// Priority scheduler controller
// Sequences job loading, exchange sort, time sums, the division and emission.
// ============================================================================
module psw_ctrl #(
  parameter int MAX_JOBS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_last,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(MAX_JOBS)-1:0]   rd_addr,
  output logic [$clog2(MAX_JOBS)-1:0]   wr_addr,
  output logic [$clog2(MAX_JOBS+1)-1:0] job_cnt,
  output psw_pkg::psw_cmd_t             cmd,
  input  psw_pkg::psw_sts_t             sts
);

  localparam int AW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_ROW_LD,
    S_CMP,
    S_ROW_WB,
    S_SUM_RD,
    S_SUM,
    S_DIV_GO,
    S_DIV,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          k_last;

  assign k_last = ((CW'(k_r) + CW'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    rd_addr       = '0;
    wr_addr       = '0;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_JOBS)) begin
            cmd.load_wr = 1'b1;
            wr_addr     = cnt_r[AW-1:0];
            cnt_nxt     = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (cnt_r > CW'(1)) begin
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          i_nxt     = '0;
          state_nxt = S_ROW_LD;
        end else begin
          state_nxt = S_SUM_RD;
        end
      end
      S_ROW_LD: begin
        cmd.cur_load = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = i_r + AW'(1);
        j_nxt        = i_r + AW'(1);
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        wr_addr      = j_r;
        if ((CW'(j_r) + CW'(1)) < cnt_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = j_r + AW'(1);
          j_nxt     = j_r + AW'(1);
        end else begin
          state_nxt = S_ROW_WB;
        end
      end
      S_ROW_WB: begin
        cmd.row_wb = 1'b1;
        wr_addr    = i_r;
        if ((CW'(i_r) + CW'(2)) < cnt_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = i_r + AW'(1);
          i_nxt     = i_r + AW'(1);
          state_nxt = S_ROW_LD;
        end else begin
          state_nxt = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        cmd.rd_en   = 1'b1;
        rd_addr     = '0;
        cmd.run_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.acc_step = 1'b1;
        if (!k_last) begin
          cmd.rd_en = 1'b1;
          rd_addr   = k_r + AW'(1);
          k_nxt     = k_r + AW'(1);
        end else begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.rd_en   = 1'b1;
          rd_addr     = '0;
          cmd.run_clr = 1'b1;
          k_nxt       = '0;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        cmd.last_res  = k_last;
        cmd.ovf       = drop_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (k_last) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = k_r + AW'(1);
            k_nxt     = k_r + AW'(1);
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign job_cnt   = cnt_r;

endmodule

>>> src/psw_dp.sv
// ============================================================================
// Priority scheduler datapath
// Job memory, sort compare, time accumulators, dividers and result register.
// ============================================================================
module psw_dp #(
  parameter int MAX_JOBS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [psw_pkg::BURST_W-1:0]       in_burst,
  input  logic [psw_pkg::PRIO_W-1:0]        in_prio,
  input  logic [$clog2(MAX_JOBS)-1:0]       rd_addr,
  input  logic [$clog2(MAX_JOBS)-1:0]       wr_addr,
  input  logic [$clog2(MAX_JOBS+1)-1:0]     job_cnt,
  input  psw_pkg::psw_cmd_t                 cmd,
  output psw_pkg::psw_sts_t                 sts,
  output psw_pkg::psw_out_t                 out_data
);

  localparam int AW  = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int EW  = psw_pkg::PRIO_W + psw_pkg::BURST_W + CW;
  localparam int TW  = psw_pkg::BURST_W + $clog2(MAX_JOBS);
  localparam int SW  = psw_pkg::BURST_W + 2 * $clog2(MAX_JOBS);
  localparam int XT  = (TW > psw_pkg::TIME_W) ? TW : psw_pkg::TIME_W + 1;
  localparam int XS  = (SW > psw_pkg::TIME_W) ? SW : psw_pkg::TIME_W + 1;
  localparam int IXW = (CW > psw_pkg::ID_W) ? CW : psw_pkg::ID_W;

  logic [EW-1:0] mem [MAX_JOBS];
  logic [EW-1:0] rdata_r;
  logic [EW-1:0] cur_r;
  logic [TW-1:0] run_r;
  logic [SW-1:0] sum_wt_r;
  logic [SW-1:0] sum_tat_r;
  psw_pkg::psw_out_t out_r;

  logic                         wr_en;
  logic [EW-1:0]                wr_data;
  logic [psw_pkg::PRIO_W-1:0]   rd_prio;
  logic [psw_pkg::BURST_W-1:0]  rd_burst;
  logic [CW-1:0]                rd_id;
  logic [psw_pkg::PRIO_W-1:0]   cur_prio;
  logic                         swap;
  logic [TW-1:0]                tat_w;
  logic [XT-1:0]                wait_ext;
  logic [XT-1:0]                tat_ext;
  logic [psw_pkg::TIME_W-1:0]   wait_sat;
  logic [psw_pkg::TIME_W-1:0]   tat_sat;
  logic [SW-1:0]                q_wt;
  logic [SW-1:0]                q_tat;
  logic [XS-1:0]                q_wt_ext;
  logic [XS-1:0]                q_tat_ext;
  logic [psw_pkg::TIME_W-1:0]   avg_wt_sat;
  logic [psw_pkg::TIME_W-1:0]   avg_tat_sat;
  logic [IXW-1:0]               id_ext;
  logic                         done_wt;
  logic                         done_tat;

  always_comb begin
    rd_prio  = rdata_r[EW-1 -: psw_pkg::PRIO_W];
    rd_burst = rdata_r[CW +: psw_pkg::BURST_W];
    rd_id    = rdata_r[CW-1:0];
    cur_prio = cur_r[EW-1 -: psw_pkg::PRIO_W];
    swap     = (cur_prio < rd_prio);
    wr_en    = cmd.load_wr | (cmd.cmp_step & swap) | cmd.row_wb;
    wr_data  = cmd.load_wr ? {in_prio, in_burst, CW'(wr_addr) + CW'(1)} : cur_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load || (cmd.cmp_step && swap)) begin
      cur_r <= rdata_r;
    end
  end

  always_comb begin
    tat_w    = run_r + TW'(rd_burst);
    wait_ext = XT'(run_r);
    tat_ext  = XT'(tat_w);
    wait_sat = (wait_ext > XT'(psw_pkg::TIME_MAX)) ? psw_pkg::TIME_MAX
                                                    : wait_ext[psw_pkg::TIME_W-1:0];
    tat_sat  = (tat_ext > XT'(psw_pkg::TIME_MAX)) ? psw_pkg::TIME_MAX
                                                   : tat_ext[psw_pkg::TIME_W-1:0];
    q_wt_ext    = XS'(q_wt);
    q_tat_ext   = XS'(q_tat);
    avg_wt_sat  = (q_wt_ext > XS'(psw_pkg::TIME_MAX)) ? psw_pkg::TIME_MAX
                                                       : q_wt_ext[psw_pkg::TIME_W-1:0];
    avg_tat_sat = (q_tat_ext > XS'(psw_pkg::TIME_MAX)) ? psw_pkg::TIME_MAX
                                                        : q_tat_ext[psw_pkg::TIME_W-1:0];
    id_ext      = IXW'(rd_id);
  end

  always_ff @(posedge clk) begin
    if (cmd.run_clr) begin
      run_r     <= '0;
      sum_wt_r  <= '0;
      sum_tat_r <= '0;
    end else if (cmd.acc_step || cmd.emit_load) begin
      run_r <= tat_w;
      if (cmd.acc_step) begin
        sum_wt_r  <= sum_wt_r + SW'(run_r);
        sum_tat_r <= sum_tat_r + SW'(tat_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_r.job_id         <= id_ext[psw_pkg::ID_W-1:0];
      out_r.job_burst      <= rd_burst;
      out_r.job_prio       <= rd_prio;
      out_r.wait_time      <= wait_sat;
      out_r.turnaround     <= tat_sat;
      out_r.avg_wait       <= avg_wt_sat;
      out_r.avg_turnaround <= avg_tat_sat;
      out_r.overflowed     <= cmd.ovf;
      out_r.final_result   <= cmd.last_res;
    end
  end

  psw_div #(
    .NW (SW),
    .DW (CW)
  ) u_div_wt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (sum_wt_r),
    .den   (job_cnt),
    .quot  (q_wt),
    .done  (done_wt)
  );

  psw_div #(
    .NW (SW),
    .DW (CW)
  ) u_div_tat (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (sum_tat_r),
    .den   (job_cnt),
    .quot  (q_tat),
    .done  (done_tat)
  );

  assign sts.div_done = done_wt & done_tat;
  assign out_data     = out_r;

endmodule

>>> src/priority_schedule_wait_times.sv
// ============================================================================
// Non-preemptive priority scheduler
// Collects a set of jobs, orders them by priority and reports wait times.
// ============================================================================
// Jobs arrive on in_ch, one transfer each, at up to one job per cycle while
// in_ch.ready is high. The job with last_job set closes the set; jobs beyond
// MAX_JOBS are dropped and every result of that set reports overflowed.
// After the closing job, in_ch.ready stays low while the set is processed:
// the exchange sort compares each row with every later job, the time sums
// read every job once, and the two averages come from bit-serial dividers,
// so the job memory port and the divider set the busy time. Results then
// leave on out_ch in run order, each loaded only after the one before it
// transfers, the last one marked final_result. A stalled out_ch holds the
// current result; in_ch.ready returns the cycle after the final result
// transfers. Reset empties the job set and clears the drop flag; the job
// memory holds no defined contents until written.
// ============================================================================
module priority_schedule_wait_times #(
  parameter int MAX_JOBS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  psw_in_if.sink     in_ch,
  psw_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);

  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [CW-1:0]     job_cnt;
  psw_pkg::psw_cmd_t cmd;
  psw_pkg::psw_sts_t sts;
  logic              in_ready;
  logic              out_valid;
  psw_pkg::psw_out_t out_data;

  psw_ctrl #(
    .MAX_JOBS (MAX_JOBS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.data.last_job),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .job_cnt   (job_cnt),
    .cmd       (cmd),
    .sts       (sts)
  );

  psw_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_burst (in_ch.data.burst),
    .in_prio  (in_ch.data.prio),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .job_cnt  (job_cnt),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

>>> src/psw_checker.sv
// ============================================================================
// Priority scheduler checker
// Port-level assertions on job loading and result delivery.
// ============================================================================
`include "priority_schedule_wait_times_defines.svh"

module psw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_job_burst,
  input logic [19:0] out_wait_time,
  input logic [19:0] out_turnaround
);

  // The block either loads jobs or delivers results, never both at once.
  `PSW_ASSERT_IMP(a_load_xor_emit, clk, rst_n, in_ready, !out_valid)

  // A closing job starts processing, so no job is taken in the next cycle.
  `PSW_ASSERT_NXT(a_close_blocks, clk, rst_n, in_valid && in_ready && in_last, !in_ready)

  // A stalled result stays offered and unchanged.
  `PSW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_wait_time) && $stable(out_job_burst))

  // Unsaturated turnaround is the wait time plus the job's own burst.
  `PSW_ASSERT_IMP(a_tat_sum, clk, rst_n, out_valid && (out_turnaround != 20'hFFFFF), (21'(out_wait_time) + 21'(out_job_burst)) == 21'(out_turnaround))

endmodule

bind priority_schedule_wait_times psw_checker u_psw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last        (in_ch.data.last_job),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_job_burst  (out_ch.data.job_burst),
  .out_wait_time  (out_ch.data.wait_time),
  .out_turnaround (out_ch.data.turnaround)
);

>>> test/priority_schedule_wait_times_tb.sv
// ============================================================================
// Priority scheduler testbench
// Loads job sets through the job channel and checks every scheduled job on
// the result channel against a priority ordering and wait-time predictor.
// Directed sets cover single jobs, field extremes, ties and a dropped job at
// the end of a full set. Random sets run under several idle and stall mixes.
// ============================================================================
module priority_schedule_wait_times_tb;

  localparam int MAX_JOBS    = 16;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_WAIT  = 80;
  localparam int ROWS        = 8;
  localparam int BURST_W     = psw_pkg::BURST_W;
  localparam int PRIO_W      = psw_pkg::PRIO_W;
  localparam int ID_W        = psw_pkg::ID_W;
  localparam int TIME_W      = psw_pkg::TIME_W;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last_job;
    logic               typed;
    psw_pkg::psw_out_t  run;
  } job_row_t;

  localparam job_row_t JOB_ROWS [ROWS] = '{
    '{16'hFFFF, 8'hFF, 1'b1, 1'b1,
      '{5'd1, 16'hFFFF, 8'hFF, 20'd0, 20'd65535, 20'd0, 20'd65535, 1'b0, 1'b1}},
    '{16'h0000, 8'h00, 1'b1, 1'b1,
      '{5'd1, 16'h0000, 8'h00, 20'd0, 20'd0, 20'd0, 20'd0, 1'b0, 1'b1}},
    '{16'd10, 8'd5, 1'b0, 1'b0, '0},
    '{16'd20, 8'd5, 1'b0, 1'b0, '0},
    '{16'd30, 8'd9, 1'b0, 1'b0, '0},
    '{16'd40, 8'd5, 1'b1, 1'b0, '0},
    '{16'hAAAA, 8'h55, 1'b0, 1'b0, '0},
    '{16'h5555, 8'hAA, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  psw_in_if  in_ch ();
  psw_out_if out_ch ();

  priority_schedule_wait_times #(
    .MAX_JOBS (MAX_JOBS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];
  logic [ID_W-1:0]    id_mem    [MAX_JOBS];
  int unsigned        held_jobs = 0;
  bit                 jobs_dropped = 1'b0;

  psw_pkg::psw_out_t pending_runs [$];

  int err_count      = 0;
  int runs_checked   = 0;
  int sets_closed    = 0;
  int sets_truncated = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_cycles    = 0;
  int cycle_count    = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [TIME_W-1:0] sat_time(input longint unsigned v);
    return (v > psw_pkg::TIME_MAX) ? psw_pkg::TIME_MAX : v[TIME_W-1:0];
  endfunction

  function automatic void schedule_job(input psw_pkg::psw_in_t job,
                                       ref psw_pkg::psw_out_t runs [$]);
    logic [BURST_W-1:0] tmp_burst;
    logic [PRIO_W-1:0]  tmp_prio;
    logic [ID_W-1:0]    tmp_id;
    longint unsigned    wait_list [MAX_JOBS];
    longint unsigned    tat_list  [MAX_JOBS];
    longint unsigned    sum_wait;
    longint unsigned    sum_tat;
    int unsigned        n;
    psw_pkg::psw_out_t  run;
    if (held_jobs < MAX_JOBS) begin
      burst_mem[held_jobs] = job.burst;
      prio_mem[held_jobs]  = job.prio;
      id_mem[held_jobs]    = ID_W'(held_jobs + 1);
      held_jobs++;
    end else begin
      jobs_dropped = 1'b1;
    end
    if (!job.last_job) return;
    n = held_jobs;
    sets_closed++;
    if (jobs_dropped) sets_truncated++;
    if (n == 0) begin
      jobs_dropped = 1'b0;
      return;
    end
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (prio_mem[i] < prio_mem[j]) begin
          tmp_prio = prio_mem[i];  prio_mem[i]  = prio_mem[j];  prio_mem[j]  = tmp_prio;
          tmp_burst = burst_mem[i]; burst_mem[i] = burst_mem[j]; burst_mem[j] = tmp_burst;
          tmp_id = id_mem[i];      id_mem[i]    = id_mem[j];    id_mem[j]    = tmp_id;
        end
      end
    end
    sum_wait = 0;
    sum_tat  = 0;
    for (int i = 0; i < n; i++) begin
      wait_list[i] = (i == 0) ? 0 : tat_list[i-1];
      tat_list[i]  = wait_list[i] + burst_mem[i];
      sum_wait += wait_list[i];
      sum_tat  += tat_list[i];
    end
    for (int i = 0; i < n; i++) begin
      run.job_id         = id_mem[i];
      run.job_burst      = burst_mem[i];
      run.job_prio       = prio_mem[i];
      run.wait_time      = sat_time(wait_list[i]);
      run.turnaround     = sat_time(tat_list[i]);
      run.avg_wait       = sat_time(sum_wait / n);
      run.avg_turnaround = sat_time(sum_tat / n);
      run.overflowed     = jobs_dropped;
      run.final_result   = (i + 1 == n);
      runs.push_back(run);
    end
    held_jobs    = 0;
    jobs_dropped = 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    psw_pkg::psw_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_runs.size() == 0) begin
        $error("result transfer with no scheduled job outstanding, job_id %0d",
               out_ch.data.job_id);
        err_count++;
      end else begin
        want = pending_runs.pop_front();
        check_field("job_id", want.job_id, out_ch.data.job_id);
        check_field("job_burst", want.job_burst, out_ch.data.job_burst);
        check_field("job_prio", want.job_prio, out_ch.data.job_prio);
        check_field("wait_time", want.wait_time, out_ch.data.wait_time);
        check_field("turnaround", want.turnaround, out_ch.data.turnaround);
        check_field("avg_wait", want.avg_wait, out_ch.data.avg_wait);
        check_field("avg_turnaround", want.avg_turnaround, out_ch.data.avg_turnaround);
        check_field("overflowed", want.overflowed, out_ch.data.overflowed);
        check_field("final_result", want.final_result, out_ch.data.final_result);
        runs_checked++;
      end
    end
  end

  // The receiver normally stalls at random; a nonzero hold_cycles keeps it
  // stalled for the whole hold-off before random stalls resume.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_runs.size());
    $display("priority_schedule_wait_times_tb: done, errors");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic put_job(input psw_pkg::psw_in_t job, input bit typed,
                         input psw_pkg::psw_out_t typed_run);
    psw_pkg::psw_out_t runs [$];
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = job;
    do @(posedge clk); while (!in_ch.ready);
    schedule_job(job, runs);
    if (typed) pending_runs.push_back(typed_run);
    else foreach (runs[k]) pending_runs.push_back(runs[k]);
    @(negedge clk);
  endtask

  task automatic put_set(input int size, input bit narrow_prio, input bit short_burst);
    psw_pkg::psw_in_t job;
    for (int k = 0; k < size; k++) begin
      job.burst    = short_burst ? BURST_W'($urandom_range(100)) : BURST_W'($urandom);
      job.prio     = narrow_prio ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
      job.last_job = (k == size - 1);
      put_job(job, 1'b0, '0);
    end
  endtask

  task automatic drain_runs();
    in_ch.valid = 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_sets(input int n_items);
    int sent;
    int size;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) size = $urandom_range(MAX_JOBS + 4, MAX_JOBS + 1);
      else if ($urandom_range(3) == 0) size = $urandom_range(3, 1);
      else size = $urandom_range(MAX_JOBS, 1);
      put_set(size, 1'($urandom_range(1)), $urandom_range(3) == 0);
      sent += size;
    end
  endtask

  initial begin
    psw_pkg::psw_in_t job;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (JOB_ROWS[r]) begin
      job.burst    = JOB_ROWS[r].burst;
      job.prio     = JOB_ROWS[r].prio;
      job.last_job = JOB_ROWS[r].last_job;
      put_job(job, JOB_ROWS[r].typed, JOB_ROWS[r].run);
    end

    // A full set of longest bursts, closed by a job that no longer fits.
    for (int i = 0; i <= MAX_JOBS; i++) begin
      job.burst    = 16'hFFFF;
      job.prio     = PRIO_W'(i * 37);
      job.last_job = (i == MAX_JOBS);
      put_job(job, 1'b0, '0);
    end
    drain_runs();

    // The receiver holds off while a second set backs up behind the first.
    hold_cycles = 800;
    put_set(MAX_JOBS, 1'b0, 1'b0);
    put_set(7, 1'b1, 1'b0);
    drain_runs();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      random_sets(100);
      if (phase == 1) drain_runs();
    end

    drain_runs();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d job sets (%0d with dropped jobs), %0d scheduled jobs checked",
             sets_closed, sets_truncated, runs_checked);
    $display("idle and stall mixes: none, sender, receiver, both; one long receiver hold-off");
    if (err_count == 0) begin
      $display("priority_schedule_wait_times_tb: done, clean");
    end else begin
      $display("priority_schedule_wait_times_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/psw_pkg.sv
src/psw_in_if.sv
src/psw_out_if.sv
src/psw_div.sv
src/psw_ctrl.sv
src/psw_dp.sv
src/priority_schedule_wait_times.sv
src/psw_checker.sv
test/priority_schedule_wait_times_tb.sv
